/* hw/rtl/glbn_pkg.sv */
package glbn_pkg;

    localparam int SEQ_W   = 5;
    localparam int SEQ_MAX = 31;
    localparam logic [SEQ_W-1:0] SEQ_MAX_V = SEQ_W'(SEQ_MAX);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    localparam logic [1:0] MODE_PKT   = 2'd0;
    localparam logic [1:0] MODE_PHY   = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;
    localparam logic [1:0] MODE_TMO   = 2'd3;

    localparam logic [2:0] ACT_SEND    = 3'd0;
    localparam logic [2:0] ACT_ACK     = 3'd1;
    localparam logic [2:0] ACT_DELIVER = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_STATUS  = 3'd4;

    localparam logic [2:0] KIND_PKT    = 3'd0;
    localparam logic [2:0] KIND_PHY    = 3'd1;
    localparam logic [2:0] KIND_RXDATA = 3'd2;
    localparam logic [2:0] KIND_RXACK  = 3'd3;
    localparam logic [2:0] KIND_TMO    = 3'd4;
    localparam logic [2:0] KIND_NOP    = 3'd5;

    typedef struct packed {
        logic [1:0]       mode;
        logic             frame_good;
        logic             frame_is_data;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] peer_ack;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
        logic             network_enable;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    function automatic logic [SEQ_W-1:0] wrap_inc(input logic [SEQ_W-1:0] k);
        return (k < SEQ_MAX_V) ? k + SEQ_W'(1) : '0;
    endfunction

    function automatic logic [SEQ_W-1:0] ack_value(input logic [SEQ_W-1:0] e);
        return (e == '0) ? SEQ_MAX_V : e - SEQ_W'(1);
    endfunction

    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

/* hw/rtl/glbn_front.sv */
module glbn_front
    import glbn_pkg::*;
(
    input  in_item_t item,
    output cmd_t     cmd
);

    always_comb
    begin
        cmd.seq  = item.frame_seq;
        cmd.ack  = item.peer_ack;
        cmd.kind = KIND_NOP;
        unique case (item.mode)
            MODE_PKT:   cmd.kind = KIND_PKT;
            MODE_PHY:   cmd.kind = KIND_PHY;
            MODE_FRAME:
            begin
                if (!item.frame_good)
                begin
                    cmd.kind = KIND_NOP;
                end
                else if (item.frame_is_data)
                begin
                    cmd.kind = KIND_RXDATA;
                end
                else
                begin
                    cmd.kind = KIND_RXACK;
                end
            end
            MODE_TMO:   cmd.kind = KIND_TMO;
            default:    cmd.kind = KIND_NOP;
        endcase
    end

endmodule

/* hw/rtl/glbn_queue.sv */
module glbn_queue
    import glbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t stat
);

    cmd_t              entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wptr_reg, wptr_next;
    logic [Q_AW-1:0]   rptr_reg, rptr_next;
    logic [Q_AW:0]     count_reg, count_next;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
    endfunction

    assign head           = entry_reg[rptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == (Q_AW + 1)'(Q_DEPTH));

    always_comb
    begin
        wptr_next  = push ? ptr_inc(wptr_reg) : wptr_reg;
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (Q_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

/* hw/rtl/glbn_back.sv */
module glbn_back
    import glbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  q_status_t q_stat,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEND1  = 3'd1;
    localparam logic [2:0] ST_DELIV  = 3'd2;
    localparam logic [2:0] ST_ACK    = 3'd3;
    localparam logic [2:0] ST_STOP   = 3'd4;
    localparam logic [2:0] ST_RESEND = 3'd5;
    localparam logic [2:0] ST_STATUS = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [SEQ_W-1:0] next_send_reg, next_send_next;
    logic [SEQ_W-1:0] outstanding_reg, outstanding_next;
    logic [SEQ_W-1:0] oldest_reg, oldest_next;
    logic [SEQ_W-1:0] expected_reg, expected_next;
    logic             phy_reg, phy_next;
    logic [SEQ_W-1:0] cur_reg, cur_next;
    logic [SEQ_W-1:0] rem_reg, rem_next;
    cmd_t             cmd_reg, cmd_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             slot;
    logic             emit;
    out_item_t        emit_item;

    assign slot         = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next       = state_reg;
        next_send_next   = next_send_reg;
        outstanding_next = outstanding_reg;
        oldest_next      = oldest_reg;
        expected_next    = expected_reg;
        phy_next         = phy_reg;
        cur_next         = cur_reg;
        rem_next         = rem_reg;
        cmd_next         = cmd_reg;
        pop              = 1'b0;
        emit             = 1'b0;
        emit_item        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.kind)
                        KIND_PKT:    state_next = ST_SEND1;
                        KIND_PHY:
                        begin
                            phy_next   = 1'b1;
                            state_next = ST_STATUS;
                        end
                        KIND_RXDATA: state_next = ST_DELIV;
                        KIND_RXACK:  state_next = ST_STOP;
                        KIND_TMO:
                        begin
                            cur_next   = oldest_reg;
                            rem_next   = outstanding_reg;
                            state_next = ST_RESEND;
                        end
                        default:     state_next = ST_STATUS;
                    endcase
                end
            end
            ST_SEND1:
            begin
                if (outstanding_reg >= SEQ_MAX_V)
                begin
                    state_next = ST_STATUS;
                end
                else if (slot)
                begin
                    emit             = 1'b1;
                    emit_item.action = ACT_SEND;
                    emit_item.seq    = next_send_reg;
                    emit_item.ack    = ack_value(expected_reg);
                    outstanding_next = outstanding_reg + SEQ_W'(1);
                    phy_next         = 1'b0;
                    next_send_next   = wrap_inc(next_send_reg);
                    state_next       = ST_STATUS;
                end
            end
            ST_DELIV:
            begin
                if (cmd_reg.seq != expected_reg)
                begin
                    state_next = ST_ACK;
                end
                else if (slot)
                begin
                    emit             = 1'b1;
                    emit_item.action = ACT_DELIVER;
                    emit_item.seq    = cmd_reg.seq;
                    expected_next    = wrap_inc(expected_reg);
                    state_next       = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (slot)
                begin
                    emit             = 1'b1;
                    emit_item.action = ACT_ACK;
                    emit_item.ack    = ack_value(expected_reg);
                    phy_next         = 1'b0;
                    state_next       = ST_STOP;
                end
            end
            ST_STOP:
            begin
                if (!(in_window(oldest_reg, cmd_reg.ack, next_send_reg)
                      && (outstanding_reg != '0)))
                begin
                    state_next = ST_STATUS;
                end
                else if (slot)
                begin
                    emit             = 1'b1;
                    emit_item.action = ACT_STOP;
                    emit_item.seq    = oldest_reg;
                    outstanding_next = outstanding_reg - SEQ_W'(1);
                    oldest_next      = wrap_inc(oldest_reg);
                end
            end
            ST_RESEND:
            begin
                if (rem_reg == '0)
                begin
                    next_send_next = cur_reg;
                    state_next     = ST_STATUS;
                end
                else if (slot)
                begin
                    emit             = 1'b1;
                    emit_item.action = ACT_SEND;
                    emit_item.seq    = cur_reg;
                    emit_item.ack    = ack_value(expected_reg);
                    phy_next         = 1'b0;
                    cur_next         = wrap_inc(cur_reg);
                    rem_next         = rem_reg - SEQ_W'(1);
                end
            end
            ST_STATUS:
            begin
                if (slot)
                begin
                    emit                     = 1'b1;
                    emit_item.action         = ACT_STATUS;
                    emit_item.network_enable = (outstanding_reg < SEQ_MAX_V) && phy_reg;
                    emit_item.last           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next       = emit_item;
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            next_send_reg   <= '0;
            outstanding_reg <= '0;
            oldest_reg      <= '0;
            expected_reg    <= '0;
            phy_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_send_reg   <= next_send_next;
            outstanding_reg <= outstanding_next;
            oldest_reg      <= oldest_next;
            expected_reg    <= expected_next;
            phy_reg         <= phy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rem_reg <= rem_next;
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

endmodule

/* hw/rtl/go_back_n_link_controller_unit.sv */
// Go-Back-N sequencing engine for one link end. Each event (packet ready,
// physical ready, frame received, timeout) is classified on transfer and
// queued in a two-entry command queue, so up to two events can be taken while
// an earlier one is still producing results. The back end handles one event
// at a time and puts out one result per cycle, while the result side does not
// stall, through its output register: deliver, data sends, ack send, timer
// stops, then the status result with last set. An event is taken in a dispatch
// step, then each result is put out in turn, and each check that yields no
// result is a step of its own. The longest event is a good in-order data frame
// that releases a full window of 31 frames; every event is paced by the single
// result register and any stall on the result side.
module go_back_n_link_controller_unit
    import glbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    cmd_t      front_cmd;
    cmd_t      q_head;
    q_status_t q_stat;
    logic      q_pop;
    logic      q_push;

    assign item_stall = q_stat.full;
    assign q_push     = item_valid && !q_stat.full;

    glbn_front u_front
    (
        .item (item),
        .cmd  (front_cmd)
    );

    glbn_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    glbn_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("command queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |->
            (result.action != ACT_STATUS) && !result.network_enable)
        else $error("non-final result carries status fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == ACT_STATUS) |->
            result.last && (result.seq == '0) && (result.ack == '0))
        else $error("status result malformed");

endmodule
